// ----- hw/rtl/fbfla_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block free list allocator: shared definitions
// Word layouts, action and status codes, controller states and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  // Action codes of an input word.
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] block_index;
  } fbfla_in_t;

  typedef struct packed {
    logic [7:0] granted_index;
    logic [1:0] status;
  } fbfla_out_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_INIT,
    FSM_ALLOC,
    FSM_FREE,
    FSM_NOP
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       init_clr;
    logic       init_step;
    logic       init_fin;
    logic       pop;
    logic       push;
    logic       emit;
    logic       grant;
    logic [1:0] res_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] new_action;
    logic       head_valid;
    logic       idx_bad;
    logic       init_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fbfla_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/fbfla_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one word at a time: the link table walk for init, the pop for
// allocate and the push for free.
// ----------------------------------------------------------------------------
module fbfla_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire fbfla_pkg::dp_sts_t   sts,
  output logic                      busy,
  output fbfla_pkg::ctrl_cmd_t      cmd
);
  import fbfla_pkg::*;

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          case (sts.new_action)
            ACT_INIT:  state_nxt = FSM_INIT;
            ACT_ALLOC: state_nxt = FSM_ALLOC;
            ACT_FREE:  state_nxt = FSM_FREE;
            default:   state_nxt = FSM_NOP;
          endcase
        end
      end
      FSM_INIT: begin
        if (sts.init_last) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_ALLOC, FSM_FREE, FSM_NOP: state_nxt = FSM_IDLE;
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = ST_OK;
    case (state_r)
      FSM_IDLE: begin
        cmd.capture  = start;
        cmd.init_clr = start && (sts.new_action == ACT_INIT);
      end
      FSM_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          cmd.init_fin = 1'b1;
          cmd.emit     = 1'b1;
        end
      end
      FSM_ALLOC: begin
        cmd.emit = 1'b1;
        if (sts.head_valid) begin
          cmd.pop   = 1'b1;
          cmd.grant = 1'b1;
        end else begin
          cmd.res_status = ST_OOM;
        end
      end
      FSM_FREE: begin
        cmd.emit = 1'b1;
        if (sts.idx_bad) begin
          cmd.res_status = ST_BAD;
        end else begin
          cmd.push = 1'b1;
        end
      end
      FSM_NOP: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state_r != FSM_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/fbfla_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator datapath
// Head pointer, init counter, link table and the result register.
// ----------------------------------------------------------------------------
module fbfla_dp #(
  parameter int POOL_BLOCKS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fbfla_pkg::fbfla_in_t in_item,
  input  wire fbfla_pkg::ctrl_cmd_t cmd,
  output fbfla_pkg::dp_sts_t        sts,
  output logic                      out_valid,
  output fbfla_pkg::fbfla_out_t     out_result
);
  import fbfla_pkg::*;

  localparam int IDX_W = $clog2(POOL_BLOCKS);
  localparam int CNT_W = $clog2(POOL_BLOCKS + 1);
  localparam int LNK_W = IDX_W + 1;
  localparam logic [7:0]       POOL_LIM = 8'(POOL_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POOL_BLOCKS - 1);

  fbfla_in_t        item_r;
  logic [IDX_W-1:0] head_r;
  logic             head_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  fbfla_out_t       out_r;

  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [LNK_W-1:0] link_wdata;
  logic [LNK_W-1:0] link_rdata;
  logic             init_last;

  assign init_last = (cnt_r == CNT_LAST);

  // Each link word holds a valid bit above the next block's index; the
  // last block of a fresh list carries a cleared valid bit.
  always_comb begin
    link_we = cmd.init_step || cmd.push;
    if (cmd.init_step) begin
      link_waddr = cnt_r[IDX_W-1:0];
      if (init_last) begin
        link_wdata = '0;
      end else begin
        link_wdata = {1'b1, cnt_r[IDX_W-1:0] + IDX_W'(1)};
      end
    end else begin
      link_waddr = item_r.block_index[IDX_W-1:0];
      link_wdata = {head_valid_r, head_r};
    end
  end

  // The table is read at the head continuously, so the head's link is ready
  // in the cycle after an allocate is accepted.
  fbfla_ram #(
    .WIDTH(LNK_W),
    .DEPTH(POOL_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(head_r),
    .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.emit) begin
      out_r.granted_index <= cmd.grant ? 8'(head_r) : 8'd0;
      out_r.status        <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      head_valid_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.init_clr) begin
        cnt_r <= '0;
      end else if (cmd.init_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.init_fin) begin
        head_r       <= '0;
        head_valid_r <= 1'b1;
      end else if (cmd.pop) begin
        head_r       <= link_rdata[IDX_W-1:0];
        head_valid_r <= link_rdata[IDX_W];
      end else if (cmd.push) begin
        head_r       <= item_r.block_index[IDX_W-1:0];
        head_valid_r <= 1'b1;
      end
    end
  end

  assign sts.new_action = in_item.action;
  assign sts.head_valid = head_valid_r;
  assign sts.idx_bad    = (item_r.block_index >= POOL_LIM);
  assign sts.init_last  = init_last;

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/fixed_block_free_list_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Keeps a pool of equal blocks on a last-in first-out free list and serves
// init, allocate and free words, one result word per input word.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge where start is high and busy is low. Its
// single result word appears on out_result for exactly one cycle with
// out_valid high, and the receiver must take it then: there is no way to
// hold results back. Allocate, free and the unused action code each keep the
// block busy in its own state (FSM_ALLOC, FSM_FREE or FSM_NOP) after
// acceptance, so no new word is taken before that state ends; the result
// shows in the cycle after it, while the next word is already being
// accepted. Init walks the link table one entry per cycle through its
// single write port, holding busy high to the last entry. Allocate pops the
// head block and returns its index, or reports out of memory when the list
// is empty (including before the first init). Free pushes a block back onto
// the head, or reports a bad block when the index lies outside the pool.
// Double frees and frees of blocks that were never handed out are not
// caught. The link table itself needs no clearing after reset: an entry is
// always written by init or free before an allocate can read it.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int POOL_BLOCKS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire fbfla_pkg::fbfla_in_t in_item,
  output logic                      out_valid,
  output fbfla_pkg::fbfla_out_t     out_result
);
  import fbfla_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // The controller decides the action's steps; it sees only start and the status group.
  fbfla_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  // The datapath holds the head pointer, the init counter, the link table
  // and the registered result word.
  fbfla_dp #(
    .POOL_BLOCKS(POOL_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_result(out_result)
  );

endmodule
`default_nettype wire
